// File: hdl/bblur_pkg.sv
// Shared types and constants for the 7x7 RGB box blur.
package bblur_pkg;

  localparam int PIX_W    = 8;
  localparam int PIX_MAX  = 255;
  localparam int NUM_CH   = 3;
  localparam int COORD_W  = 10;
  localparam int DIM_W    = 11;
  localparam int ROW_LIMIT = 1024;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WINDOW_DEF    = 7;
  localparam int OUT_DEPTH     = 8;

  // channel lanes inside the column sums
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   mean_red;
    logic [PIX_W-1:0]   mean_green;
    logic [PIX_W-1:0]   mean_blue;
    logic               window_full;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } pix_out_t;

endpackage

// File: hdl/bblur_line_store.sv
// Line store holding the last lines per column, and the column sum of each new column.
module bblur_line_store #(
  parameter int MAX_WIDTH = 1024,
  parameter int LINES     = 6,
  parameter int CS_W      = 11
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]            rd_addr,
  input  bblur_pkg::pix_in_t                      pix_in,
  output logic                                    col_vld,
  output logic [bblur_pkg::NUM_CH-1:0][CS_W-1:0]  col_sum
);
  import bblur_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  // each entry keeps one column of the last lines, oldest in slot 0
  pix_in_t [LINES-1:0] line_mem [MAX_WIDTH];

  pix_in_t [LINES-1:0] rd_q_r;
  pix_in_t [LINES-1:0] entry_nxt;
  pix_in_t             pix_d_r;
  logic [COL_W-1:0]    col_d_r;
  logic                stg_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r  <= line_mem[rd_addr];
      pix_d_r <= pix_in;
      col_d_r <= rd_addr;
    end
    if (stg_vld_r) begin
      line_mem[col_d_r] <= entry_nxt;
    end
  end

  // drop the oldest line, append the new pixel
  always_comb begin
    for (int t = 0; t < LINES - 1; t++) begin
      entry_nxt[t] = rd_q_r[t + 1];
    end
    entry_nxt[LINES-1] = pix_d_r;
  end

  always_comb begin
    col_sum[CH_RED]   = CS_W'(pix_d_r.pixel_red);
    col_sum[CH_GREEN] = CS_W'(pix_d_r.pixel_green);
    col_sum[CH_BLUE]  = CS_W'(pix_d_r.pixel_blue);
    for (int t = 0; t < LINES; t++) begin
      col_sum[CH_RED]   = col_sum[CH_RED]   + CS_W'(rd_q_r[t].pixel_red);
      col_sum[CH_GREEN] = col_sum[CH_GREEN] + CS_W'(rd_q_r[t].pixel_green);
      col_sum[CH_BLUE]  = col_sum[CH_BLUE]  + CS_W'(rd_q_r[t].pixel_blue);
    end
  end

  assign col_vld = stg_vld_r;

endmodule

// File: hdl/bblur_col_cell.sv
// One window column: holds the column sums of three channels and passes them left.
module bblur_col_cell #(
  parameter int CS_W = 11
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    shift_en,
  input  logic [bblur_pkg::NUM_CH-1:0][CS_W-1:0]  col_in,
  output logic [bblur_pkg::NUM_CH-1:0][CS_W-1:0]  col_out
);
  import bblur_pkg::*;

  logic [NUM_CH-1:0][CS_W-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

// File: hdl/bblur_out_fifo.sv
// Output queue that holds finished results while the receiver stalls.
module bblur_out_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  bblur_pkg::pix_out_t  wr_data,
  input  logic                 rd_en,
  output logic                 rd_vld,
  output bblur_pkg::pix_out_t  rd_data
);
  import bblur_pkg::*;

  localparam int AW = $clog2(DEPTH);

  pix_out_t       store_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    cnt_r;
  logic [AW:0]    cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_vld  = (cnt_r != '0);
  assign rd_data = store_r[rd_ptr_r];

endmodule

// File: hdl/box_blur_7x7_rgb.sv
// Top level of the 7x7 RGB box blur: position counters, column cell chain, divide and output.
//
// Pixels enter in raster order on the in_ channel (valid/ready), one transaction per
// pixel, and every pixel yields exactly one result on the out_ channel: the truncated
// mean of the window whose bottom-right corner is that pixel, tagged with the window
// centre's row and column. Where the window leaves the image the means are zero and
// window_full is clear.
// The cfg_ channel writes image_width (index 0) or image_height (index 1) and restarts
// the frame; write it only while no pixel is in flight. cfg_ready is always high.
// Throughput is one pixel per cycle while in_ready is high, set by the line store, which
// does one read and one write of a whole column of stored lines each cycle. A result
// passes from the edge that accepts its pixel to out_valid through these steps: line
// store read at that edge, then column sum into the cell chain, window sum, multiply by
// the reciprocal of the window area, output queue.
// Up to 8 pixels may be pending; when the receiver stalls the queue fills and in_ready
// drops until results are taken. Reset sets width 640 and height 480, clears the
// counters and cell chain; the line store is not cleared and needs no clearing pass.
module box_blur_7x7_rgb #(
  parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF,
  parameter int WINDOW    = bblur_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bblur_pkg::pix_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bblur_pkg::pix_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bblur_pkg::DIM_W-1:0]        cfg_data
);
  import bblur_pkg::*;

  localparam int LINES    = WINDOW - 1;
  localparam int HALF     = WINDOW / 2;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = COORD_W;
  localparam int WL_W     = (DIM_W > $clog2(MAX_WIDTH + 1)) ? DIM_W : $clog2(MAX_WIDTH + 1);
  localparam int CS_W     = $clog2(WINDOW * PIX_MAX + 1);
  localparam int AREA     = WINDOW * WINDOW;
  localparam int SUM_W    = $clog2(AREA * PIX_MAX + 1);
  localparam int DIV_SH   = SUM_W + $clog2(AREA);
  localparam longint DIV_MUL = ((longint'(1) << DIV_SH) + longint'(AREA) - 1) / longint'(AREA);
  localparam int MUL_W    = $clog2(DIV_MUL + 1);
  localparam int PROD_W   = SUM_W + MUL_W;
  localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic               full;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } meta_t;

  logic              in_acc;
  logic              out_acc;
  logic              cfg_acc;
  logic              cfg_hit;

  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic [WL_W-1:0]   width_ext;
  logic [WL_W-1:0]   width_eff;
  logic [DIM_W-1:0]  height_eff;
  logic              col_last;
  logic              row_last;

  meta_t             meta_in;
  meta_t             meta1_r, meta2_r, meta3_r, meta4_r;
  logic              v2_r, v3_r, v4_r;

  logic                         col_vld;
  logic [NUM_CH-1:0][CS_W-1:0]  col_sum;
  logic [NUM_CH-1:0][CS_W-1:0]  cell_q [WINDOW];
  logic [NUM_CH-1:0][SUM_W-1:0] win_sum;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_r;
  logic [NUM_CH-1:0][PROD_W-1:0] prod_r;
  logic [NUM_CH-1:0][PIX_W-1:0] mean;
  pix_out_t                     res;

  logic [CREDIT_W-1:0] pend_r, pend_nxt;

  assign in_ready  = (pend_r < CREDIT_W'(OUT_DEPTH));
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // clamp the frame size to what the line store and counters hold
  always_comb begin
    width_ext = WL_W'(width_r);
    if (width_ext == '0) begin
      width_eff = WL_W'(1);
    end else if (width_ext > WL_W'(MAX_WIDTH)) begin
      width_eff = WL_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (height_r == '0) begin
      height_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(ROW_LIMIT)) begin
      height_eff = DIM_W'(ROW_LIMIT);
    end else begin
      height_eff = height_r;
    end
    col_last = (WL_W'(col_r) + WL_W'(1)) >= width_eff;
    row_last = (DIM_W'(row_r) + DIM_W'(1)) >= height_eff;
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    cfg_hit    = 1'b0;
    if (cfg_acc) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          width_nxt = cfg_data;
          cfg_hit   = 1'b1;
        end
        CFG_HEIGHT: begin
          height_nxt = cfg_data;
          cfg_hit    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    meta_in.full = (32'(row_r) >= 32'(WINDOW - 1)) && (32'(col_r) >= 32'(WINDOW - 1));
    meta_in.center_row = (32'(row_r) >= 32'(HALF)) ? COORD_W'(32'(row_r) - 32'(HALF)) : '0;
    meta_in.center_col = (32'(col_r) >= 32'(HALF)) ? COORD_W'(32'(col_r) - 32'(HALF)) : '0;
  end

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + CREDIT_W'(1);
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - CREDIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      pend_r   <= '0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pend_r   <= pend_nxt;
      v2_r     <= col_vld;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
    end
  end

  // meta1_r loads on each accepted pixel; later payload stages advance every cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meta1_r <= meta_in;
    end
    meta2_r <= meta1_r;
    meta3_r <= meta2_r;
    meta4_r <= meta3_r;
    sum_r   <= win_sum;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod_r[ch] <= PROD_W'(sum_r[ch]) * PROD_W'(DIV_MUL);
    end
  end

  bblur_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .LINES     (LINES),
    .CS_W      (CS_W)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .pix_in  (in_data),
    .col_vld (col_vld),
    .col_sum (col_sum)
  );

  // newest column enters at the right end, the oldest falls off the left
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == WINDOW - 1) begin : g_head
      bblur_col_cell #(.CS_W(CS_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (col_vld),
        .col_in   (col_sum),
        .col_out  (cell_q[k])
      );
    end else begin : g_body
      bblur_col_cell #(.CS_W(CS_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (col_vld),
        .col_in   (cell_q[k+1]),
        .col_out  (cell_q[k])
      );
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      win_sum[ch] = '0;
      for (int k = 0; k < WINDOW; k++) begin
        win_sum[ch] = win_sum[ch] + SUM_W'(cell_q[k][ch]);
      end
    end
  end

  // reciprocal multiply gives the exact truncated quotient over the whole sum range
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      mean[ch] = prod_r[ch][DIV_SH +: PIX_W];
    end
    res.mean_red    = meta4_r.full ? mean[CH_RED]   : '0;
    res.mean_green  = meta4_r.full ? mean[CH_GREEN] : '0;
    res.mean_blue   = meta4_r.full ? mean[CH_BLUE]  : '0;
    res.window_full = meta4_r.full;
    res.center_row  = meta4_r.center_row;
    res.center_col  = meta4_r.center_col;
  end

  bblur_out_fifo #(.DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (v4_r),
    .wr_data (res),
    .rd_en   (out_acc),
    .rd_vld  (out_valid),
    .rd_data (out_data)
  );

endmodule

// File: verif/tb.sv
// Self-checking testbench for the 7x7 RGB box blur: predicts every window mean and checks it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bblur_pkg::*;

  localparam int WIN          = WINDOW_DEF;
  localparam int HALF         = WIN / 2;
  localparam int LINES        = WIN - 1;
  localparam int MAXW         = MAX_WIDTH_DEF;
  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_PRINTS   = 100;

  // indexes past the register list: the block must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {PAT_WHITE, PAT_BLACK, PAT_SATURATED, PAT_NOISE} pixel_pattern_e;

  class blur_scoreboard;
    logic [23:0] lines [LINES][MAXW];
    logic [23:0] win [WIN][WIN];
    int          row_pos;
    int          col_pos;
    int          width_reg;
    int          height_reg;
    pix_out_t    mean_q[$];
    int          errors;

    function new();
      foreach (lines[t, c]) lines[t][c] = '0;
      foreach (win[t, k]) win[t][k] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = int'(WIDTH_RST);
      height_reg = int'(HEIGHT_RST);
      errors     = 0;
    endfunction

    function int clamp_dim(int v, int limit);
      if (v < 1) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function int size();
      return mean_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_WIDTH: begin
          width_reg = int'(val);
          row_pos   = 0;
          col_pos   = 0;
        end
        CFG_HEIGHT: begin
          height_reg = int'(val);
          row_pos    = 0;
          col_pos    = 0;
        end
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted pixel transaction and queue it.
    function void note(pix_in_t px);
      pix_out_t    want;
      int          w;
      int          h;
      int          sr;
      int          sg;
      int          sb;
      logic [23:0] p;
      bit          full;
      w  = clamp_dim(width_reg, MAXW);
      h  = clamp_dim(height_reg, ROW_LIMIT);
      sr = 0;
      sg = 0;
      sb = 0;
      for (int t = 0; t < WIN; t++)
        for (int k = 0; k < WIN - 1; k++) win[t][k] = win[t][k + 1];
      // line t of the window holds the row that is WIN-1-t lines above
      for (int t = 0; t < LINES; t++) win[t][WIN - 1] = lines[(row_pos + t) % LINES][col_pos];
      win[WIN - 1][WIN - 1] = px;
      lines[row_pos % LINES][col_pos] = px;
      full = (row_pos >= WIN - 1) && (col_pos >= WIN - 1);
      if (full) begin
        for (int t = 0; t < WIN; t++) begin
          for (int k = 0; k < WIN; k++) begin
            p  = win[t][k];
            sr += int'(p[23:16]);
            sg += int'(p[15:8]);
            sb += int'(p[7:0]);
          end
        end
        sr /= WIN * WIN;
        sg /= WIN * WIN;
        sb /= WIN * WIN;
      end
      want.mean_red    = PIX_W'(sr);
      want.mean_green  = PIX_W'(sg);
      want.mean_blue   = PIX_W'(sb);
      want.window_full = full;
      want.center_row  = COORD_W'((row_pos >= HALF) ? row_pos - HALF : 0);
      want.center_col  = COORD_W'((col_pos >= HALF) ? col_pos - HALF : 0);
      mean_q.push_back(want);
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want,
                       pix_out_t at);
      if (got !== want)
        report($sformatf("%s got %0h want %0h (centre row %0d col %0d)", name, got, want,
                         at.center_row, at.center_col));
    endtask

    task check(pix_out_t got);
      pix_out_t want;
      if (mean_q.size() == 0) begin
        report($sformatf("result transaction %h with none expected", got));
        return;
      end
      want = mean_q.pop_front();
      compare_field("mean_red", COORD_W'(got.mean_red), COORD_W'(want.mean_red), want);
      compare_field("mean_green", COORD_W'(got.mean_green), COORD_W'(want.mean_green), want);
      compare_field("mean_blue", COORD_W'(got.mean_blue), COORD_W'(want.mean_blue), want);
      compare_field("window_full", COORD_W'(got.window_full), COORD_W'(want.window_full), want);
      compare_field("center_row", got.center_row, want.center_row, want);
      compare_field("center_col", got.center_col, want.center_col, want);
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pix_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pix_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  blur_scoreboard sb = new();
  bit             tx_idle_en  = 1'b1;
  bit             rx_idle_en  = 1'b1;
  bit             first_phase = 1'b1;
  int             items_sent  = 0;
  int             cycle_count = 0;

  box_blur_7x7_rgb i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("box_blur_7x7_rgb test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  // Receiver: ready in random bursts, held high while idling is off.
  initial begin : result_sink
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_idle_en && $urandom_range(0, 3) == 0) out_ready = 1'b0;
      else out_ready = 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  function automatic pix_in_t rand_pixel(pixel_pattern_e pat);
    pix_in_t p;
    case (pat)
      PAT_WHITE: p = '1;
      PAT_BLACK: p = '0;
      PAT_SATURATED: begin
        p.pixel_red   = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        p.pixel_green = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        p.pixel_blue  = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      default: p = pix_in_t'(24'($urandom));
    endcase
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_pixel(pix_in_t px);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (!in_ready);
    sb.note(px);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every queued result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(bit allow_idle, int target);
    int             sel;
    int             w;
    int             h;
    int             count;
    int             pause_at;
    pixel_pattern_e pat;
    logic [DIM_W-1:0] wv;
    drain();
    tx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
    rx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0: pat = PAT_WHITE;
      1: pat = PAT_BLACK;
      2: pat = PAT_SATURATED;
      default: pat = PAT_NOISE;
    endcase
    sel = $urandom_range(0, 15);
    if (first_phase) begin
      // smallest frame, all white: a single full window at full scale
      write_reg(CFG_WIDTH, DIM_W'(WIN));
      write_reg(CFG_HEIGHT, DIM_W'(WIN));
      pat   = PAT_WHITE;
      count = WIN * WIN;
    end else if (sel == 0) begin
      // wide line, partial frame; widths past the limit clamp
      wv = ($urandom_range(0, 1) != 0) ? 11'h7FF : DIM_W'($urandom_range(1000, 1024));
      write_reg(CFG_HEIGHT, DIM_W'($urandom_range(7, 9)));
      write_reg(CFG_WIDTH, wv);
      count = $urandom_range(30, 80);
    end else if (sel == 1) begin
      // spare index: position carries on from the previous phase
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                DIM_W'($urandom_range(0, 2047)));
      count = $urandom_range(5, 30);
    end else begin
      if (sel == 2) begin
        w = $urandom_range(21, 48);
        h = $urandom_range(7, 8);
      end else begin
        w = $urandom_range(7, 16);
        h = $urandom_range(7, 10);
      end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(CFG_WIDTH, DIM_W'(w));
        write_reg(CFG_HEIGHT, DIM_W'(h));
      end else begin
        write_reg(CFG_HEIGHT, DIM_W'(h));
        write_reg(CFG_WIDTH, DIM_W'(w));
      end
      count = (sel == 2) ? w * h : w * h * $urandom_range(1, 2);
      // broken frame: cut short at a random point
      if ($urandom_range(0, 7) == 0) count = $urandom_range(1, w * h);
    end
    // stop the phase at the item budget of this part of the run
    if (count > target - items_sent) count = target - items_sent;
    pause_at = -1;
    if (count >= 10 && (first_phase || $urandom_range(0, 2) == 0))
      pause_at = $urandom_range(1, count - 1);
    first_phase = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      send_pixel(rand_pixel(pat));
    end
    in_valid = 1'b0;
  endtask

  initial begin : stimulus
    int guard;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes of each channel at the reset frame size
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
    send_pixel(24'hAA55AA);
    drain();
    // spare indexes must neither store nor restart the frame
    write_reg(CFG_SPARE_LO, 11'h555);
    write_reg(CFG_SPARE_HI, 11'h2AA);
    send_pixel(24'h55AA55);
    send_pixel(24'h123456);
    drain();
    // zero sizes behave as a one-pixel frame
    write_reg(CFG_WIDTH, 11'h000);
    write_reg(CFG_HEIGHT, 11'h000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h808080);
    drain();
    // oversize registers clamp to the largest frame
    write_reg(CFG_WIDTH, 11'h7FF);
    write_reg(CFG_HEIGHT, 11'h7FF);
    repeat (4) send_pixel(rand_pixel(PAT_NOISE));
    in_valid = 1'b0;

    while (items_sent < 1450) run_phase(1'b1, 1450);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (items_sent < 1650) run_phase(1'b0, 1650);

    guard = 0;
    while (sb.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.size() != 0) sb.report($sformatf("%0d expected results never arrived", sb.size()));
    if (sb.errors == 0) begin
      $display("box_blur_7x7_rgb test passed");
    end else begin
      $display("box_blur_7x7_rgb test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/bblur_pkg.sv
hdl/bblur_line_store.sv
hdl/bblur_col_cell.sv
hdl/bblur_out_fifo.sv
hdl/box_blur_7x7_rgb.sv
verif/tb.sv
